### src/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bright spot counter.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CSB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define CSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/csbsc_pkg.sv
//------------------------------------------------------------------------------
// csbsc_pkg
// Constants shared by the cross stencil bright spot counter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package csbsc_pkg;

   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_PIXEL_BITS  = 8;

   localparam int PIXEL_IN_W = 8;
   localparam int COUNT_W    = 20;
   localparam int CNT_REG_W  = 11;
   localparam int THR_W      = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CNT_REG_W-1:0] COLUMN_RESET = 11'd1024;
   localparam logic [CNT_REG_W-1:0] ROW_RESET    = 11'd1024;
   localparam logic [THR_W-1:0]     THR_RESET    = 8'd6;

   localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
   localparam logic [1:0] REG_THRESHOLD    = 2'd2;

endpackage

### src/csbsc_if.sv
//------------------------------------------------------------------------------
// csbsc stream interfaces
// Valid/ready channels for pixel items and count items.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

interface csbsc_req_if import csbsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_IN_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface csbsc_rsp_if import csbsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] star_count;

   modport source (output valid, output star_count, input ready);
   modport sink   (input valid, input star_count, output ready);
endinterface

### src/csbsc_rows.sv
//------------------------------------------------------------------------------
// csbsc_rows
// Two line stores with registered reads and write-to-read forwarding.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module csbsc_rows import csbsc_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
   localparam int XW = $clog2(MAX_COLUMNS)
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [XW-1:0]         rd_col,
   input  logic                  wr_en,
   input  logic [XW-1:0]         wr_col,
   input  logic [PIXEL_BITS-1:0] wr_upper,
   input  logic [PIXEL_BITS-1:0] wr_middle,
   output logic [PIXEL_BITS-1:0] upper_q,
   output logic [PIXEL_BITS-1:0] middle_q
);

   logic [PIXEL_BITS-1:0] upper_mem  [MAX_COLUMNS];
   logic [PIXEL_BITS-1:0] middle_mem [MAX_COLUMNS];
   logic [XW-1:0]         rd_mid_col;

   assign rd_mid_col = rd_col + XW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_col] <= wr_upper;
      end
      if (rd_en) begin
         if (wr_en && wr_col == rd_col) begin
            upper_q <= wr_upper;
         end else begin
            upper_q <= upper_mem[rd_col];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         middle_mem[wr_col] <= wr_middle;
      end
      if (rd_en) begin
         if (wr_en && wr_col == rd_mid_col) begin
            middle_q <= wr_middle;
         end else begin
            middle_q <= middle_mem[rd_mid_col];
         end
      end
   end

endmodule

### src/cross_stencil_bright_spot_counter.sv
//------------------------------------------------------------------------------
// cross_stencil_bright_spot_counter
// Counts interior pixels whose five-point cross mean, rounded down, exceeds a threshold.
//------------------------------------------------------------------------------
// Pixels enter on req_ch in raster order, one item per cycle when valid and
// ready are both high. Each pixel completes the cross centered one row above
// it; border rows and columns never count. On the last pixel of a frame one
// count item leaves on rsp_ch via the input and output registers; no other
// pixel gives an item. Sustained throughput is one pixel per cycle unless a
// count stalls: an input register stage reads both line stores, and from it
// the sum and compare feed the tally and the output register.
// Frame size and threshold are set over the APB port (column_count at 0x0,
// row_count at 0x4, brightness_threshold at 0x8); write them between frames.
// Reset restores 1024 x 1024 and threshold 6, clears position and tally, and
// needs no clearing pass: line store entries are used only after written.
// When rsp_ch stalls, the count waits in the output register while pixels
// keep flowing; only the next frame-end pixel holds req_ch.ready low until the
// earlier count is taken.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cross_stencil_bright_spot_counter import csbsc_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   csbsc_req_if.sink             req_ch,
   csbsc_rsp_if.source           rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int XW    = $clog2(MAX_COLUMNS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int CCW   = $clog2(MAX_COLUMNS + 1);
   localparam int RCW   = $clog2(MAX_ROWS + 1);
   localparam int SW    = PIXEL_BITS + 3;
   localparam int TW    = THR_W + 3;
   localparam int CMP_W = (SW > TW) ? SW : TW;

   // configuration
   logic [CNT_REG_W-1:0] col_reg_ff;
   logic [CNT_REG_W-1:0] row_reg_ff;
   logic [THR_W-1:0]     thr_reg_ff;
   logic                 csr_wr;
   logic [CCW-1:0]       cols_eff;
   logic [RCW-1:0]       rows_eff;

   // position and input stage
   logic [XW-1:0]         col_ff, col_in;
   logic [YW-1:0]         row_ff, row_in;
   logic [PIXEL_BITS-1:0] pix_w;
   logic                  accept;
   logic [XW+1:0]         c_x, c_p1, c_p2, cols_x;
   logic [YW:0]           r_x, r_p1, rows_x;
   logic                  last_col, last_row;

   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [XW-1:0]         s1_col_ff;
   logic                  s1_first_ff, s1_row_ge1_ff, s1_t2_ok_ff, s1_judge_ff, s1_last_ff;
   logic                  s1_advance, s1_fire;

   // stencil
   logic [PIXEL_BITS-1:0] tap1_ff, tap2_ff, col0_ff;
   logic [PIXEL_BITS-1:0] t0, t1, t2;
   logic [PIXEL_BITS-1:0] upper_q, middle_q;
   logic [SW-1:0]         sum;
   logic [TW-1:0]         thr5;
   logic                  hit;
   logic [COUNT_W-1:0]    tally_ff, tally_in;

   logic                  rsp_valid_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   //--------------------------------------------------------------------------
   // APB registers
   //--------------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_reg_ff <= COLUMN_RESET;
         row_reg_ff <= ROW_RESET;
         thr_reg_ff <= THR_RESET;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_COLUMN_COUNT: col_reg_ff <= pwdata[CNT_REG_W-1:0];
            REG_ROW_COUNT:    row_reg_ff <= pwdata[CNT_REG_W-1:0];
            REG_THRESHOLD:    thr_reg_ff <= pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_COLUMN_COUNT: prdata = CSR_DATA_W'(col_reg_ff);
         REG_ROW_COUNT:    prdata = CSR_DATA_W'(row_reg_ff);
         REG_THRESHOLD:    prdata = CSR_DATA_W'(thr_reg_ff);
         default:          prdata = '0;
      endcase
   end

   assign cols_eff = (col_reg_ff == '0) ? CCW'(1) :
                     (32'(col_reg_ff) > MAX_COLUMNS) ? CCW'(MAX_COLUMNS) : CCW'(col_reg_ff);
   assign rows_eff = (row_reg_ff == '0) ? RCW'(1) :
                     (32'(row_reg_ff) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(row_reg_ff);

   //--------------------------------------------------------------------------
   // Input stage: position, flags, line store read
   //--------------------------------------------------------------------------
   for (genvar i = 0; i < PIXEL_BITS; i++) begin : g_pix
      if (i < PIXEL_IN_W) begin : g_bit
         assign pix_w[i] = req_ch.pixel_value[i];
      end else begin : g_zero
         assign pix_w[i] = 1'b0;
      end
   end

   assign s1_advance   = !(s1_last_ff && rsp_valid_ff && !rsp_ch.ready);
   assign s1_fire      = s1_valid_ff && s1_advance;
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign c_x    = (XW+2)'(col_ff);
   assign c_p1   = c_x + (XW+2)'(1);
   assign c_p2   = c_x + (XW+2)'(2);
   assign cols_x = (XW+2)'(cols_eff);
   assign r_x    = (YW+1)'(row_ff);
   assign r_p1   = r_x + (YW+1)'(1);
   assign rows_x = (YW+1)'(rows_eff);

   assign last_col = c_p1 >= cols_x;
   assign last_row = r_p1 >= rows_x;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : r_p1[YW-1:0];
      end else begin
         col_in = c_p1[XW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= pix_w;
         s1_col_ff     <= col_ff;
         s1_first_ff   <= col_ff == '0;
         s1_row_ge1_ff <= row_ff != '0;
         s1_t2_ok_ff   <= (row_ff != '0) && (c_p1 < cols_x)
                          && (c_p1 < (XW+2)'(MAX_COLUMNS));
         s1_judge_ff   <= (r_x >= (YW+1)'(2)) && (r_x < rows_x)
                          && (col_ff != '0) && (c_p2 <= cols_x);
         s1_last_ff    <= last_col && last_row;
      end
   end

   csbsc_rows #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .PIXEL_BITS  (PIXEL_BITS)
   ) u_rows (
      .clock     (clock),
      .rd_en     (accept),
      .rd_col    (col_ff),
      .wr_en     (s1_fire),
      .wr_col    (s1_col_ff),
      .wr_upper  (t1),
      .wr_middle (s1_pix_ff),
      .upper_q   (upper_q),
      .middle_q  (middle_q)
   );

   //--------------------------------------------------------------------------
   // Stencil stage: sum, compare, tally
   //--------------------------------------------------------------------------
   always_comb begin
      if (s1_first_ff) begin
         t0 = '0;
         t1 = s1_row_ge1_ff ? col0_ff : '0;
      end else begin
         t0 = tap1_ff;
         t1 = tap2_ff;
      end
      t2   = s1_t2_ok_ff ? middle_q : '0;
      sum  = SW'(upper_q) + SW'(t0) + SW'(t1) + SW'(t2) + SW'(s1_pix_ff);
      thr5 = (TW'(thr_reg_ff) + TW'(1)) * TW'(5);
      hit  = s1_judge_ff && (CMP_W'(sum) >= CMP_W'(thr5)) && (tally_ff != COUNT_MAX);
      tally_in = tally_ff + COUNT_W'(hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap1_ff      <= '0;
         tap2_ff      <= '0;
         col0_ff      <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_fire) begin
            tap1_ff  <= t1;
            tap2_ff  <= t2;
            tally_ff <= s1_last_ff ? '0 : tally_in;
            if (s1_first_ff) begin
               col0_ff <= s1_pix_ff;
            end
         end
         if (s1_fire && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         rsp_count_ff <= tally_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.star_count = rsp_count_ff;

   //--------------------------------------------------------------------------
   // Assertions
   //--------------------------------------------------------------------------
   `CSB_ASSERT_NOW(a_hold_on_full, clock, reset,
      s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ch.ready, !req_ch.ready)
   `CSB_ASSERT_NEXT(a_tally_clear, clock, reset, s1_fire && s1_last_ff, tally_ff == '0)
   `CSB_ASSERT_NOW(a_rsp_source, clock, reset,
      $rose(rsp_valid_ff), $past(s1_valid_ff && s1_last_ff))

endmodule
